FILE: sv/mvs_pkg.sv
// Shared types and constants for the mean / variance / standard deviation block.
// Used by mvs_ctrl, mvs_datapath and mean_variance_stddev; depends on nothing else.
package mvs_pkg;

    // Finishing phases that the datapath runs one after another.
    typedef enum logic [2:0] {
        PH_MUL_NSQ,
        PH_MUL_SS,
        PH_MUL_NN,
        PH_DIV_MEAN,
        PH_DIV_VAR,
        PH_SQRT
    } phase_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL_NSQ,
        ST_MUL_SS,
        ST_MUL_NN,
        ST_DIV_MEAN,
        ST_DIV_VAR,
        ST_SQRT,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic   acc;
        logic   load;
        logic   step;
        logic   publish;
        phase_t phase;
    } dp_cmd_t;

    typedef struct packed {
        logic iter_last;
        logic out_free;
    } dp_sts_t;

    // The square root works on a 31-bit variance: 16 steps of two bits each.
    localparam int          SQRT_STEPS = 16;
    localparam logic [31:0] SQRT_BIT0  = 32'h4000_0000;

endpackage

FILE: sv/mvs_ctrl.sv
// Controller state machine for the mean / variance / standard deviation block.
// Depends on mvs_pkg; drives the command struct of mvs_datapath.
module mvs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    output mvs_pkg::dp_cmd_t  cmd,
    input  mvs_pkg::dp_sts_t  sts
);

    mvs_pkg::state_t state_reg, state_next;
    mvs_pkg::state_t after_state;
    logic            load_reg, load_next;
    logic            busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mvs_pkg::ST_ACC;
            load_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            load_reg  <= load_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        load_next   = load_reg;
        after_state = mvs_pkg::ST_ACC;
        busy        = 1'b0;
        s_tready    = 1'b0;
        cmd.acc     = 1'b0;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.publish = 1'b0;
        cmd.phase   = mvs_pkg::PH_MUL_NSQ;

        unique case (state_reg)
            mvs_pkg::ST_ACC: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.acc = 1'b1;
                    if (s_tlast) begin
                        state_next = mvs_pkg::ST_MUL_NSQ;
                        load_next  = 1'b1;
                    end
                end
            end
            mvs_pkg::ST_MUL_NSQ: begin
                busy        = 1'b1;
                cmd.phase   = mvs_pkg::PH_MUL_NSQ;
                after_state = mvs_pkg::ST_MUL_SS;
            end
            mvs_pkg::ST_MUL_SS: begin
                busy        = 1'b1;
                cmd.phase   = mvs_pkg::PH_MUL_SS;
                after_state = mvs_pkg::ST_MUL_NN;
            end
            mvs_pkg::ST_MUL_NN: begin
                busy        = 1'b1;
                cmd.phase   = mvs_pkg::PH_MUL_NN;
                after_state = mvs_pkg::ST_DIV_MEAN;
            end
            mvs_pkg::ST_DIV_MEAN: begin
                busy        = 1'b1;
                cmd.phase   = mvs_pkg::PH_DIV_MEAN;
                after_state = mvs_pkg::ST_DIV_VAR;
            end
            mvs_pkg::ST_DIV_VAR: begin
                busy        = 1'b1;
                cmd.phase   = mvs_pkg::PH_DIV_VAR;
                after_state = mvs_pkg::ST_SQRT;
            end
            mvs_pkg::ST_SQRT: begin
                busy        = 1'b1;
                cmd.phase   = mvs_pkg::PH_SQRT;
                after_state = mvs_pkg::ST_PUBLISH;
            end
            mvs_pkg::ST_PUBLISH: begin
                if (sts.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = mvs_pkg::ST_ACC;
                end
            end
            default: begin
                state_next = mvs_pkg::ST_ACC;
            end
        endcase

        // Each phase first loads its operands, then iterates.
        if (busy) begin
            if (load_reg) begin
                cmd.load  = 1'b1;
                load_next = 1'b0;
            end else begin
                cmd.step = 1'b1;
                if (sts.iter_last) begin
                    state_next = after_state;
                    load_next  = 1'b1;
                end
            end
        end
    end

endmodule

FILE: sv/mvs_datapath.sv
// Datapath for the mean / variance / standard deviation block: accumulators,
// shift-add multiplier, restoring divider, bit-pair square root, output register.
// Depends on mvs_pkg; commanded by mvs_ctrl.
module mvs_datapath #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mvs_pkg::dp_cmd_t   cmd,
    output mvs_pkg::dp_sts_t   sts,
    input  logic signed [15:0] sample,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [71:0]        m_tdata,
    output logic               m_tuser
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);  // count
    localparam int SW = 16 + CW;                  // signed sum
    localparam int MW = SW - 1;                   // sum magnitude, multiplier operand
    localparam int QW = 30 + CW;                  // sum of squares
    localparam int NW = 30 + 2 * CW;              // variance numerator
    localparam int DW = 2 * CW;                   // count squared
    localparam int IW = $clog2(NW + 1);           // iteration counter

    logic signed [SW-1:0] sum_reg;
    logic [QW-1:0]        sq_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 drop_reg;

    logic [NW-1:0] mul_a_reg;
    logic [MW-1:0] mul_b_reg;
    logic [NW-1:0] mul_p_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;

    logic [NW-1:0] dvd_reg;
    logic [DW-1:0] dsr_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;

    logic [15:0] mean_reg;
    logic [30:0] var_reg;
    logic [30:0] rt_v_reg;
    logic [31:0] rt_root_reg;
    logic [31:0] rt_bit_reg;
    logic [IW-1:0] it_reg;

    logic        out_valid_reg;
    logic [15:0] out_mean_reg;
    logic [30:0] out_var_reg;
    logic [15:0] out_std_reg;
    logic [6:0]  out_cnt_reg;
    logic        out_ovf_reg;

    logic signed [31:0] sample_sq;
    logic [SW-1:0]      sum_neg;
    logic [MW-1:0]      sum_mag;
    logic               cnt_full;
    logic [NW-1:0]      num_diff;
    logic [DW:0]        div_sh;
    logic [DW:0]        div_sub;
    logic               div_ge;
    logic [15:0]        q_lo;
    logic [15:0]        mean_val;
    logic [32:0]        rt_try;
    logic               rt_ge;
    logic [CW+6:0]      cnt_wide;

    assign sample_sq = sample * sample;
    assign sum_neg   = -sum_reg;
    assign sum_mag   = sum_reg[SW-1] ? sum_neg[MW-1:0] : sum_reg[MW-1:0];
    assign cnt_full  = (cnt_reg == CW'(MAX_SAMPLES));
    assign num_diff  = (num_reg >= mul_p_reg) ? (num_reg - mul_p_reg) : '0;

    assign div_sh  = {rem_reg, dvd_reg[NW-1]};
    assign div_sub = div_sh - {1'b0, dsr_reg};
    assign div_ge  = (div_sh >= {1'b0, dsr_reg});

    // Floor division of a negative sum: negate the magnitude quotient and
    // step one further down when the division was inexact.
    assign q_lo     = quo_reg[15:0] + 16'(rem_reg != '0);
    assign mean_val = sum_reg[SW-1] ? (16'd0 - q_lo) : quo_reg[15:0];

    assign rt_try = {1'b0, rt_root_reg} + {1'b0, rt_bit_reg};
    assign rt_ge  = ({2'b00, rt_v_reg} >= rt_try);

    assign cnt_wide = (CW + 7)'(cnt_reg);

    assign sts.iter_last = (it_reg == IW'(1));
    assign sts.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            sq_reg        <= '0;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            it_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.publish) begin
                sum_reg  <= '0;
                sq_reg   <= '0;
                cnt_reg  <= '0;
                drop_reg <= 1'b0;
            end else if (cmd.acc) begin
                if (!cnt_full) begin
                    sum_reg <= sum_reg + SW'(sample);
                    sq_reg  <= sq_reg + QW'(sample_sq[30:0]);
                    cnt_reg <= cnt_reg + 1'b1;
                end else begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.load) begin
                unique case (cmd.phase)
                    mvs_pkg::PH_MUL_NSQ,
                    mvs_pkg::PH_MUL_SS,
                    mvs_pkg::PH_MUL_NN:   it_reg <= IW'(MW);
                    mvs_pkg::PH_DIV_MEAN,
                    mvs_pkg::PH_DIV_VAR:  it_reg <= IW'(NW);
                    mvs_pkg::PH_SQRT:     it_reg <= IW'(mvs_pkg::SQRT_STEPS);
                    default:              it_reg <= '0;
                endcase
            end else if (cmd.step) begin
                it_reg <= it_reg - 1'b1;
            end
            if (cmd.publish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            unique case (cmd.phase)
                mvs_pkg::PH_MUL_NSQ: begin
                    mul_a_reg <= NW'(sq_reg);
                    mul_b_reg <= MW'(cnt_reg);
                    mul_p_reg <= '0;
                end
                mvs_pkg::PH_MUL_SS: begin
                    num_reg   <= mul_p_reg;
                    mul_a_reg <= NW'(sum_mag);
                    mul_b_reg <= sum_mag;
                    mul_p_reg <= '0;
                end
                mvs_pkg::PH_MUL_NN: begin
                    num_reg   <= num_diff;
                    mul_a_reg <= NW'(cnt_reg);
                    mul_b_reg <= MW'(cnt_reg);
                    mul_p_reg <= '0;
                end
                mvs_pkg::PH_DIV_MEAN: begin
                    den_reg <= mul_p_reg[DW-1:0];
                    dvd_reg <= NW'(sum_mag);
                    dsr_reg <= DW'(cnt_reg);
                    rem_reg <= '0;
                    quo_reg <= '0;
                end
                mvs_pkg::PH_DIV_VAR: begin
                    mean_reg <= mean_val;
                    dvd_reg  <= num_reg;
                    dsr_reg  <= den_reg;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                end
                mvs_pkg::PH_SQRT: begin
                    var_reg     <= quo_reg[30:0];
                    rt_v_reg    <= quo_reg[30:0];
                    rt_root_reg <= '0;
                    rt_bit_reg  <= mvs_pkg::SQRT_BIT0;
                end
                default: begin
                end
            endcase
        end else if (cmd.step) begin
            unique case (cmd.phase)
                mvs_pkg::PH_MUL_NSQ,
                mvs_pkg::PH_MUL_SS,
                mvs_pkg::PH_MUL_NN: begin
                    if (mul_b_reg[0]) begin
                        mul_p_reg <= mul_p_reg + mul_a_reg;
                    end
                    mul_a_reg <= mul_a_reg << 1;
                    mul_b_reg <= mul_b_reg >> 1;
                end
                mvs_pkg::PH_DIV_MEAN,
                mvs_pkg::PH_DIV_VAR: begin
                    quo_reg <= {quo_reg[NW-2:0], div_ge};
                    rem_reg <= div_ge ? div_sub[DW-1:0] : div_sh[DW-1:0];
                    dvd_reg <= dvd_reg << 1;
                end
                mvs_pkg::PH_SQRT: begin
                    if (rt_ge) begin
                        rt_v_reg    <= rt_v_reg - rt_try[30:0];
                        rt_root_reg <= (rt_root_reg >> 1) + rt_bit_reg;
                    end else begin
                        rt_root_reg <= rt_root_reg >> 1;
                    end
                    rt_bit_reg <= rt_bit_reg >> 2;
                end
                default: begin
                end
            endcase
        end
        if (cmd.publish) begin
            out_mean_reg <= mean_reg;
            out_var_reg  <= var_reg;
            out_std_reg  <= rt_root_reg[15:0];
            out_cnt_reg  <= cnt_wide[6:0];
            out_ovf_reg  <= drop_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_cnt_reg, out_std_reg, out_var_reg, out_mean_reg};
    assign m_tuser  = out_ovf_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_SAMPLES))
        else $error("sample count passed its limit");

    a_drop_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        drop_reg |-> cnt_full)
        else $error("drop flag set on a set that is not full");

    a_drop_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc && cnt_full && !cmd.publish) |=> drop_reg)
        else $error("sample beyond the limit was not flagged");

    a_sqrt_bracket: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
            ((33'(out_std_reg) * 33'(out_std_reg)) <= 33'(out_var_reg)) &&
            (((33'(out_std_reg) + 33'd1) * (33'(out_std_reg) + 33'd1)) > 33'(out_var_reg)))
        else $error("standard deviation is not the floor root of the variance");
`endif

endmodule

FILE: sv/mean_variance_stddev.sv
// Top level of the population mean / variance / standard deviation block.
// Depends on mvs_pkg, mvs_ctrl and mvs_datapath.
//
// Usage: samples enter on the s_ stream one beat at a time, signed Q7.8 in
// s_tdata, and s_tlast marks the final sample of a set. Each beat that is not
// the last is absorbed when it is accepted: the running sum, sum of squares
// and count update and s_tready stays high, so a set streams in at one sample
// per cycle. After the last beat the block works out the statistics with a
// shift-add multiplier (three passes over an operand of SW - 1 bits), a
// restoring divider (two passes over an NW-bit dividend) and a square root
// that works two bits per step, where SW = 16 + CW, NW = 30 + 2*CW and
// CW = clog2(MAX_SAMPLES + 1). s_tready is low until the result moves into
// the output register. Samples past MAX_SAMPLES in one set are dropped and
// reported through m_tuser. The result sits in an output register: the next
// set may stream in while it waits for m_tready, and apart from the finishing
// work the block only stalls its input if a second set finishes before the
// first result is taken. Reset (aresetn low at a clock edge) clears the sums,
// the count and the output valid flag.
module mean_variance_stddev #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [15:0] sample
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    // m_tdata: [15:0] mean_out, [46:16] variance_out, [62:47] std_dev_out,
    //          [69:63] sample_count, [71:70] zero
    // m_tuser: [0] overflow
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    output logic        m_tuser
);

    mvs_pkg::dp_cmd_t cmd;
    mvs_pkg::dp_sts_t sts;

    // The controller owns the handshake and sequences the finishing phases.
    mvs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath holds the accumulators, the iterative arithmetic and the
    // output register that decouples the result from the input side.
    mvs_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .sample   (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: sim/tb_mean_variance_stddev.sv
// Self-checking testbench for mean_variance_stddev: streams sets of Q7.8 samples,
// predicts each set's statistics in place and checks every result beat.
// Depends only on the mean_variance_stddev RTL and its package.
module tb_mean_variance_stddev;
    timeunit 1ns;
    timeprecision 1ps;

    // Set length cap handed to the block; sets longer than this get truncated.
    localparam int SET_CAP = 64;

    // How the samples of one set are drawn.
    typedef enum int {
        FL_UNIFORM,
        FL_EXTREME,
        FL_CLUSTER
    } flavor_t;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } sample_beat_t;

    typedef struct {
        logic [15:0] mean;
        logic [30:0] variance;
        logic [15:0] std_dev;
        logic [6:0]  count;
        logic        overflow;
    } stats_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;

    // Beats waiting to be offered, and statistics waiting to come out.
    sample_beat_t sample_queue[$];
    stats_t       stats_due[$];

    // Running statistics of the set that is currently streaming in.
    longint set_sum = 0;
    longint set_sumsq = 0;
    longint set_count = 0;
    bit     set_dropped = 1'b0;

    int error_count = 0;
    int results_seen = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int holds_done = 0;
    int calm_left = 0;
    bit calm = 1'b0;

    mean_variance_stddev #(
        .MAX_SAMPLES(SET_CAP)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Reset is held at the start and never again.
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    task automatic report_mismatch(string field, longint got, longint want);
        if (error_count < 50)
            $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // Idle lengths: mostly none or short, now and then a long one. During a calm
    // stretch every idle length picked is zero.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 200);
    endfunction

    function automatic logic [15:0] pick_sample(flavor_t fl, logic [15:0] anchor);
        case (fl)
            FL_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            // A tight cluster keeps the variance small and exercises the
            // cancellation between n * sum of squares and the squared sum.
            FL_CLUSTER: return anchor + 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_beat(logic [15:0] sample, logic last);
        sample_beat_t b;
        b.sample = sample;
        b.last = last;
        sample_queue.push_back(b);
    endtask

    task automatic queue_set(int len, flavor_t fl);
        logic [15:0] anchor;
        anchor = 16'($urandom);
        for (int i = 0; i < len; i++)
            push_beat(pick_sample(fl, anchor), i == len - 1);
    endtask

    // Folds one accepted sample into the running set. The closing sample
    // produces the population statistics and starts a fresh set. Divisions
    // round toward minus infinity, so the mean of a negative sum is adjusted.
    task automatic absorb_sample(logic [15:0] raw, logic last);
        longint s;
        longint q;
        longint num;
        longint root;
        longint cand;
        stats_t st;
        s = longint'($signed(raw));
        if (set_count < SET_CAP) begin
            set_sum += s;
            set_sumsq += s * s;
            set_count++;
        end else begin
            // Past the cap the sample is dropped, but it may still close the set.
            set_dropped = 1'b1;
        end
        if (last) begin
            q = set_sum / set_count;
            if (set_sum % set_count != 0 && set_sum < 0)
                q--;
            num = set_count * set_sumsq - set_sum * set_sum;
            if (num < 0)
                num = 0;
            num = num / (set_count * set_count);
            // Floor square root, one result bit at a time from the top.
            root = 0;
            for (int b = 16; b >= 0; b--) begin
                cand = root + (longint'(1) << b);
                if (cand * cand <= num)
                    root = cand;
            end
            st.mean = q[15:0];
            st.variance = num[30:0];
            st.std_dev = root[15:0];
            st.count = set_count[6:0];
            st.overflow = set_dropped;
            stats_due.push_back(st);
            set_sum = 0;
            set_sumsq = 0;
            set_count = 0;
            set_dropped = 1'b0;
        end
    endtask

    // Toggles calm stretches in which every idle gap picked is zero.
    always @(posedge aclk) begin
        if (calm_left > 0) begin
            calm_left <= calm_left - 1;
        end else begin
            calm_left <= $urandom_range(100, 400);
            calm <= ($urandom_range(0, 3) == 0);
        end
    end

    // Sender: a beat is accepted when tvalid and tready are both high at the
    // edge. Only then, or while nothing is offered, does the next beat or an
    // idle cycle get set up, so tvalid never drops under a pending beat.
    always @(posedge aclk) begin
        sample_beat_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready)
                absorb_sample(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    b = sample_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= b.sample;
                    s_tlast <= b.last;
                    send_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs, counted here in cycles. Each lasts well past the
    // block's finishing time, so a second set completes while the first result
    // still sits in the output register and the input has to stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            holds_done <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if ((holds_done == 0 && results_seen >= 3)
                     || (holds_done == 1 && results_seen >= 30)) begin
            hold_left <= 600;
            holds_done <= holds_done + 1;
        end
    end

    // Receiver: checks each accepted result beat against the oldest prediction,
    // then decides whether to be ready on the next cycle.
    always @(posedge aclk) begin
        stats_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (stats_due.size() == 0) begin
                    report_mismatch("unexpected result beat, mean_out",
                                    $signed(m_tdata[15:0]), 0);
                end else begin
                    want = stats_due.pop_front();
                    if (m_tdata[15:0] !== want.mean)
                        report_mismatch("mean_out", $signed(m_tdata[15:0]),
                                        $signed(want.mean));
                    if (m_tdata[46:16] !== want.variance)
                        report_mismatch("variance_out", m_tdata[46:16], want.variance);
                    if (m_tdata[62:47] !== want.std_dev)
                        report_mismatch("std_dev_out", m_tdata[62:47], want.std_dev);
                    if (m_tdata[69:63] !== want.count)
                        report_mismatch("sample_count", m_tdata[69:63], want.count);
                    if (m_tuser !== want.overflow)
                        report_mismatch("overflow", m_tuser, want.overflow);
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    recv_gap <= pick_gap();
            end
        end
    end

    // Stimulus, then the wait for the last result and the verdict.
    initial begin
        int random_items;
        int len;
        int r;
        flavor_t fl;

        // Single-sample sets at both ends of the range and at zero.
        push_beat(16'h8000, 1'b1);
        push_beat(16'h7FFF, 1'b1);
        push_beat(16'h0000, 1'b1);
        // A mean of minus one half must round down to minus one.
        push_beat(16'hFFFF, 1'b0);
        push_beat(16'h0000, 1'b1);
        // The widest spread two samples can have.
        push_beat(16'h8000, 1'b0);
        push_beat(16'h7FFF, 1'b1);
        push_beat(16'h0001, 1'b0);
        push_beat(16'h0002, 1'b0);
        push_beat(16'h0003, 1'b0);
        push_beat(16'h0004, 1'b1);
        // Negative sum that does not divide evenly.
        push_beat(16'hFFFD, 1'b0);
        push_beat(16'hFFFD, 1'b0);
        push_beat(16'hFFFE, 1'b1);
        // Four-sample constant sets at the extremes: zero variance, largest sums.
        for (int i = 0; i < 4; i++)
            push_beat(16'h7FFF, i == 3);
        for (int i = 0; i < 4; i++)
            push_beat(16'h8000, i == 3);

        // Random sets: mostly short, some long, some exactly at the cap and
        // some past it so that dropped samples, including a dropped closing
        // sample, come up regularly.
        random_items = 0;
        while (random_items < 1350) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                len = $urandom_range(1, 12);
            else if (r < 80)
                len = $urandom_range(13, SET_CAP - 2);
            else if (r < 90)
                len = $urandom_range(SET_CAP - 1, SET_CAP + 1);
            else
                len = $urandom_range(SET_CAP + 2, SET_CAP + 30);
            fl = flavor_t'($urandom_range(0, 2));
            queue_set(len, fl);
            random_items += len;
        end

        wait (aresetn);
        while (sample_queue.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (stats_due.size() != 0)
            @(posedge aclk);
        repeat (250) @(posedge aclk);
        if (error_count == 0)
            $display("[mean_variance_stddev] OK");
        else
            $display("[mean_variance_stddev] ERROR");
        $finish;
    end

    // Safety net far beyond the slowest correct run.
    initial begin
        #40ms;
        $display("[mean_variance_stddev] ERROR");
        $finish;
    end

endmodule
